// ===== src/tpuv_pkg.sv =====
// Package for the triplanar UDIM UV projector: word types, register
// indexes, status and axis codes, and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package tpuv_pkg;

  // Input word: one shading point.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               pos_found;
    logic               norm_found;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [17:0] u_coord;
    logic [15:0] v_coord;
    logic [1:0]  axis_used;
    logic [1:0]  status;
  } result_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_X_LINEAR  = 3'd0;
  localparam logic [2:0] REG_X_OFFSET  = 3'd1;
  localparam logic [2:0] REG_Y_LINEAR  = 3'd2;
  localparam logic [2:0] REG_Y_OFFSET  = 3'd3;
  localparam logic [2:0] REG_Z_LINEAR  = 3'd4;
  localparam logic [2:0] REG_Z_OFFSET  = 3'd5;
  localparam logic [2:0] REG_MIRROR    = 3'd6;
  localparam logic [2:0] REG_PROJ_OK   = 3'd7;

  // Status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_PROJECTOR = 2'd1;
  localparam logic [1:0] ST_POS_MISSING  = 2'd2;
  localparam logic [1:0] ST_NORM_MISSING = 2'd3;

  // Axis codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Only the low 28 bits of the products reach the 16 wrapped fraction
  // bits (16 kept bits above the 12 coefficient fraction bits).
  localparam int unsigned ACC_W = 28;

  localparam logic [ACC_W-1:0] HALF_Q16 = ACC_W'(32'h0000_8000);
  localparam logic [ACC_W-1:0] ONE_Q16  = ACC_W'(32'h0001_0000);

  // UDIM tile offsets on u: one tile minus one LSB, two tiles minus one LSB.
  localparam logic [17:0] TILE_Y = 18'h0_FFFF;
  localparam logic [17:0] TILE_Z = 18'h1_FFFF;

endpackage

// ===== src/tpuv_lane.sv =====
// Two-stage multiply-accumulate lane: c_a*u + c_b*v, scaled down by the
// coefficient fraction bits, plus offset, wrapped to 16 fraction bits. Uses tpuv_pkg.
`timescale 1ns / 1ps

module tpuv_lane (
  input  logic                       clk,
  input  logic [tpuv_pkg::ACC_W-1:0] u,
  input  logic [tpuv_pkg::ACC_W-1:0] v,
  input  logic [15:0]                coef_a,
  input  logic [15:0]                coef_b,
  input  logic [15:0]                offset,
  output logic [15:0]                wrapped
);

  logic [tpuv_pkg::ACC_W-1:0] coef_a_ext;
  logic [tpuv_pkg::ACC_W-1:0] coef_b_ext;
  logic [tpuv_pkg::ACC_W-1:0] prod_a;
  logic [tpuv_pkg::ACC_W-1:0] prod_b;
  logic [15:0]                offset_d;
  logic [tpuv_pkg::ACC_W-1:0] acc;

  // Everything is taken modulo 2^28, so signed and unsigned products agree
  // once the coefficients are sign extended.
  assign coef_a_ext = {{(tpuv_pkg::ACC_W-16){coef_a[15]}}, coef_a};
  assign coef_b_ext = {{(tpuv_pkg::ACC_W-16){coef_b[15]}}, coef_b};

  always_ff @(posedge clk) begin
    prod_a   <= tpuv_pkg::ACC_W'(u * coef_a_ext);
    prod_b   <= tpuv_pkg::ACC_W'(v * coef_b_ext);
    offset_d <= offset;
  end

  assign acc = prod_a + prod_b;

  always_ff @(posedge clk) begin
    wrapped <= acc[tpuv_pkg::ACC_W-1:12] + offset_d;
  end

endmodule

// ===== src/triplanar_udim_uv_projector.sv =====
// Top level of the triplanar UDIM UV projector: configuration registers,
// axis pick, swizzle and mirror, two tpuv_lane instances, and the result stage. Uses tpuv_pkg.
`timescale 1ns / 1ps

// Channel   Ports                              Handshake
// -------   --------------------------------   --------------------------------
// input     in_word (tpuv_pkg::in_word_t)      taken when start & !busy
// config    cfg_index, cfg_data                written when cfg_valid & cfg_ready
// result    result (tpuv_pkg::result_t)        valid for one cycle with done
//
// The block is a five-stage pipeline: axis pick and status, swizzle and
// mirror, products, sum with offset and wrap, then the tile offset. Each
// word's result is on the ports with done once it has left the last stage,
// and a word can be taken on every clock. busy stays low: the receiver
// cannot hold results off, so nothing ever waits inside the block. The
// configuration port is always ready. rst clears the registers and all stage
// valid bits; words in flight are dropped.

module triplanar_udim_uv_projector (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tpuv_pkg::in_word_t  in_word,
  output logic                busy,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic                done,
  output tpuv_pkg::result_t   result
);

  // Configuration registers.
  logic [63:0] x_linear, x_offset, y_linear, y_offset, z_linear, z_offset;
  logic        mirror_enable, projector_ok;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_linear      <= '0;
      x_offset      <= '0;
      y_linear      <= '0;
      y_offset      <= '0;
      z_linear      <= '0;
      z_offset      <= '0;
      mirror_enable <= 1'b0;
      projector_ok  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpuv_pkg::REG_X_LINEAR: x_linear      <= cfg_data;
        tpuv_pkg::REG_X_OFFSET: x_offset      <= cfg_data;
        tpuv_pkg::REG_Y_LINEAR: y_linear      <= cfg_data;
        tpuv_pkg::REG_Y_OFFSET: y_offset      <= cfg_data;
        tpuv_pkg::REG_Z_LINEAR: z_linear      <= cfg_data;
        tpuv_pkg::REG_Z_OFFSET: z_offset      <= cfg_data;
        tpuv_pkg::REG_MIRROR:   mirror_enable <= cfg_data[0];
        tpuv_pkg::REG_PROJ_OK:  projector_ok  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: status check and axis pick from the normal magnitudes.
  // Magnitudes are 17 bits so that the most negative normal gives 32768.
  // Ties go to the earlier axis because only a strictly larger value wins.
  // ---------------------------------------------------------------------
  logic [16:0] mag_x, mag_y, mag_z, mag_best;
  logic [1:0]  axis_pick, status_pick;

  assign mag_x = in_word.norm_x[15] ? (17'd0 - {1'b1, in_word.norm_x}) : {1'b0, in_word.norm_x};
  assign mag_y = in_word.norm_y[15] ? (17'd0 - {1'b1, in_word.norm_y}) : {1'b0, in_word.norm_y};
  assign mag_z = in_word.norm_z[15] ? (17'd0 - {1'b1, in_word.norm_z}) : {1'b0, in_word.norm_z};

  always_comb begin
    axis_pick = tpuv_pkg::AXIS_X;
    mag_best  = mag_x;
    if (mag_y > mag_x) begin
      axis_pick = tpuv_pkg::AXIS_Y;
      mag_best  = mag_y;
    end
    if (mag_z > mag_best) begin
      axis_pick = tpuv_pkg::AXIS_Z;
    end
  end

  always_comb begin
    if (!projector_ok) begin
      status_pick = tpuv_pkg::ST_NO_PROJECTOR;
    end else if (!in_word.pos_found) begin
      status_pick = tpuv_pkg::ST_POS_MISSING;
    end else if (!in_word.norm_found) begin
      status_pick = tpuv_pkg::ST_NORM_MISSING;
    end else begin
      status_pick = tpuv_pkg::ST_OK;
    end
  end

  logic                       s1_valid;
  logic [1:0]                 s1_axis, s1_status;
  logic [tpuv_pkg::ACC_W-1:0] s1_px, s1_py, s1_pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  // Only the low bits of the position can reach the wrapped result.
  always_ff @(posedge clk) begin
    s1_axis   <= axis_pick;
    s1_status <= status_pick;
    s1_px     <= in_word.pos_x[tpuv_pkg::ACC_W-1:0];
    s1_py     <= in_word.pos_y[tpuv_pkg::ACC_W-1:0];
    s1_pz     <= in_word.pos_z[tpuv_pkg::ACC_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Stage 2: add one half, swizzle by axis, mirror, and select the axis's
  // coefficients and offsets.
  // X axis: u = z, v = y, mirror u.  Y axis: u = x, v = z, mirror v.
  // Z axis: u = x, v = y, mirror u.
  // ---------------------------------------------------------------------
  logic [tpuv_pkg::ACC_W-1:0] hx, hy, hz, u_sel, v_sel;
  logic [63:0]                lin_sel, off_sel;

  assign hx = s1_px + tpuv_pkg::HALF_Q16;
  assign hy = s1_py + tpuv_pkg::HALF_Q16;
  assign hz = s1_pz + tpuv_pkg::HALF_Q16;

  always_comb begin
    case (s1_axis)
      tpuv_pkg::AXIS_Y: begin
        u_sel   = hx;
        v_sel   = mirror_enable ? (tpuv_pkg::ONE_Q16 - hz) : hz;
        lin_sel = y_linear;
        off_sel = y_offset;
      end
      tpuv_pkg::AXIS_Z: begin
        u_sel   = mirror_enable ? (tpuv_pkg::ONE_Q16 - hx) : hx;
        v_sel   = hy;
        lin_sel = z_linear;
        off_sel = z_offset;
      end
      default: begin
        u_sel   = mirror_enable ? (tpuv_pkg::ONE_Q16 - hz) : hz;
        v_sel   = hy;
        lin_sel = x_linear;
        off_sel = x_offset;
      end
    endcase
  end

  logic                       s2_valid;
  logic [1:0]                 s2_axis, s2_status;
  logic [tpuv_pkg::ACC_W-1:0] s2_u, s2_v;
  logic [63:0]                s2_lin;
  logic [15:0]                s2_off_u, s2_off_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // Only the low 16 bits of each offset survive the wrap.
  always_ff @(posedge clk) begin
    s2_axis   <= s1_axis;
    s2_status <= s1_status;
    s2_u      <= u_sel;
    s2_v      <= v_sel;
    s2_lin    <= lin_sel;
    s2_off_u  <= off_sel[15:0];
    s2_off_v  <= off_sel[47:32];
  end

  // ---------------------------------------------------------------------
  // Stages 3 and 4: the two lanes register their products, then the wrapped
  // sum. The axis, status and valid bit travel alongside.
  // ---------------------------------------------------------------------
  logic [15:0] u_wrapped, v_wrapped;

  tpuv_lane u_lane (
    .clk     (clk),
    .u       (s2_u),
    .v       (s2_v),
    .coef_a  (s2_lin[15:0]),
    .coef_b  (s2_lin[31:16]),
    .offset  (s2_off_u),
    .wrapped (u_wrapped)
  );

  tpuv_lane v_lane (
    .clk     (clk),
    .u       (s2_u),
    .v       (s2_v),
    .coef_a  (s2_lin[47:32]),
    .coef_b  (s2_lin[63:48]),
    .offset  (s2_off_v),
    .wrapped (v_wrapped)
  );

  logic       s3_valid, s4_valid;
  logic [1:0] s3_axis, s3_status, s4_axis, s4_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_axis   <= s2_axis;
    s3_status <= s2_status;
    s4_axis   <= s3_axis;
    s4_status <= s3_status;
  end

  // ---------------------------------------------------------------------
  // Stage 5: UDIM tile offset on u, and zero fields for any failed status.
  // ---------------------------------------------------------------------
  logic [17:0]       tile;
  tpuv_pkg::result_t result_next;

  always_comb begin
    case (s4_axis)
      tpuv_pkg::AXIS_Y: tile = tpuv_pkg::TILE_Y;
      tpuv_pkg::AXIS_Z: tile = tpuv_pkg::TILE_Z;
      default:          tile = 18'd0;
    endcase
  end

  always_comb begin
    if (s4_status == tpuv_pkg::ST_OK) begin
      result_next.u_coord   = {2'b00, u_wrapped} + tile;
      result_next.v_coord   = v_wrapped;
      result_next.axis_used = s4_axis;
      result_next.status    = tpuv_pkg::ST_OK;
    end else begin
      result_next.u_coord   = '0;
      result_next.v_coord   = '0;
      result_next.axis_used = tpuv_pkg::AXIS_X;
      result_next.status    = s4_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ===== verif/tb_triplanar_udim_uv_projector.sv =====
// Testbench for triplanar_udim_uv_projector: directed and random shading points,
// checked against an in-bench predictor of the UV projection. Uses tpuv_pkg.
`timescale 1ns / 1ps

module tb_triplanar_udim_uv_projector;

  // The pipeline is five stages deep; settle() waits past this depth to cover stray words.
  localparam int PIPE_DEPTH     = 5;
  localparam int STALL_LIMIT    = 2000;
  localparam int POINTS_PER_SET = 200;
  localparam int RANDOM_SETS    = 6;

  logic               clk;
  logic               rst;
  logic               start;
  tpuv_pkg::in_word_t in_word;
  logic               busy;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_data;
  logic               done;
  tpuv_pkg::result_t  result;

  triplanar_udim_uv_projector u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the register file, indexed by axis code.
  logic [63:0] axis_lin [3];
  logic [63:0] axis_off [3];
  logic        mirror_on;
  logic        projector_ready;

  // UV words predicted for accepted points, oldest first.
  tpuv_pkg::result_t expected_uv [$];

  int points_sent;
  int results_seen;
  int reg_writes;
  int error_count;
  int quiet_cycles;

  // Sum of two products floored to Q16.16, plus the offset, keeping only the
  // 16 fraction bits. Bits [27:12] of the product sum are exactly the bits
  // that survive the wrap, so no wider shift is needed.
  function automatic logic [15:0] fold_q16(input logic signed [63:0] cu,
                                           input logic signed [63:0] cv,
                                           input logic [15:0] ca,
                                           input logic [15:0] cb,
                                           input logic [31:0] off);
    logic signed [63:0] ka;
    logic signed [63:0] kb;
    logic signed [63:0] acc;
    ka  = $signed(ca);
    kb  = $signed(cb);
    acc = cu * ka + cv * kb;
    return acc[27:12] + off[15:0];
  endfunction

  // Predicted result word for one shading point under the current registers.
  function automatic tpuv_pkg::result_t predict_uv(input tpuv_pkg::in_word_t w);
    tpuv_pkg::result_t r;
    int nx, ny, nz;
    int mag_x, mag_y, mag_z, best;
    logic [1:0] axis;
    logic signed [63:0] sx, sy, sz, cu, cv;
    logic [63:0] lin, off;
    logic [15:0] fu, fv;
    r = '0;
    if (!projector_ready) begin
      r.status = tpuv_pkg::ST_NO_PROJECTOR;
      return r;
    end
    if (!w.pos_found) begin
      r.status = tpuv_pkg::ST_POS_MISSING;
      return r;
    end
    if (!w.norm_found) begin
      r.status = tpuv_pkg::ST_NORM_MISSING;
      return r;
    end
    // The most negative normal component has magnitude 32768 here, since the
    // magnitude is taken in 32 bits.
    nx = $signed(w.norm_x);
    ny = $signed(w.norm_y);
    nz = $signed(w.norm_z);
    mag_x = (nx < 0) ? -nx : nx;
    mag_y = (ny < 0) ? -ny : ny;
    mag_z = (nz < 0) ? -nz : nz;
    // Strict comparisons so that equal magnitudes keep the earlier axis.
    axis = tpuv_pkg::AXIS_X;
    best = mag_x;
    if (mag_y > best) begin
      axis = tpuv_pkg::AXIS_Y;
      best = mag_y;
    end
    if (mag_z > best) begin
      axis = tpuv_pkg::AXIS_Z;
    end
    sx = $signed(w.pos_x);
    sy = $signed(w.pos_y);
    sz = $signed(w.pos_z);
    sx = sx + 64'sd32768;
    sy = sy + 64'sd32768;
    sz = sz + 64'sd32768;
    case (axis)
      tpuv_pkg::AXIS_Y: begin
        cu = sx;
        cv = sz;
        if (mirror_on) cv = 64'sd65536 - cv;
      end
      tpuv_pkg::AXIS_Z: begin
        cu = sx;
        cv = sy;
        if (mirror_on) cu = 64'sd65536 - cu;
      end
      default: begin
        cu = sz;
        cv = sy;
        if (mirror_on) cu = 64'sd65536 - cu;
      end
    endcase
    lin = axis_lin[axis];
    off = axis_off[axis];
    fu = fold_q16(cu, cv, lin[15:0], lin[31:16], off[31:0]);
    fv = fold_q16(cu, cv, lin[47:32], lin[63:48], off[63:32]);
    r.u_coord   = {2'b00, fu};
    if (axis == tpuv_pkg::AXIS_Y) r.u_coord = r.u_coord + tpuv_pkg::TILE_Y;
    if (axis == tpuv_pkg::AXIS_Z) r.u_coord = r.u_coord + tpuv_pkg::TILE_Z;
    r.v_coord   = fv;
    r.axis_used = axis;
    r.status    = tpuv_pkg::ST_OK;
    return r;
  endfunction

  function automatic tpuv_pkg::in_word_t make_point(input logic [31:0] px,
                                                    input logic [31:0] py,
                                                    input logic [31:0] pz,
                                                    input logic [15:0] nx,
                                                    input logic [15:0] ny,
                                                    input logic [15:0] nz,
                                                    input logic pf, input logic nf);
    tpuv_pkg::in_word_t w;
    w.pos_x      = px;
    w.pos_y      = py;
    w.pos_z      = pz;
    w.norm_x     = nx;
    w.norm_y     = ny;
    w.norm_z     = nz;
    w.pos_found  = pf;
    w.norm_found = nf;
    return w;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom_range(32'h3_FFFF)) - 32'h2_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_norm();
    case ($urandom_range(11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Random shading point: mostly both fetches found, now and then a forced
  // tie between normal magnitudes.
  function automatic tpuv_pkg::in_word_t rand_point();
    tpuv_pkg::in_word_t w;
    w = make_point(rand_pos(), rand_pos(), rand_pos(), rand_norm(), rand_norm(), rand_norm(),
                   $urandom_range(99) < 92, $urandom_range(99) < 92);
    case ($urandom_range(7))
      0: w.norm_y = $urandom_range(1) ? w.norm_x : -w.norm_x;
      1: w.norm_z = $urandom_range(1) ? w.norm_y : -w.norm_y;
      2: w.norm_z = $urandom_range(1) ? w.norm_x : -w.norm_x;
      default: ;
    endcase
    return w;
  endfunction

  // Offers one word and waits until the block takes it. With a chance of
  // gap_pct percent, start drops for a random run of idle cycles afterward.
  task automatic send_point(input tpuv_pkg::in_word_t w, input int gap_pct);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_uv.insert(expected_uv.size(), predict_uv(w));
    points_sent++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
  endtask

  // Stops issuing and waits until every predicted word has come back, then
  // lets the pipeline run empty.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_uv.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tpuv_pkg::REG_X_LINEAR: axis_lin[tpuv_pkg::AXIS_X] = data;
      tpuv_pkg::REG_X_OFFSET: axis_off[tpuv_pkg::AXIS_X] = data;
      tpuv_pkg::REG_Y_LINEAR: axis_lin[tpuv_pkg::AXIS_Y] = data;
      tpuv_pkg::REG_Y_OFFSET: axis_off[tpuv_pkg::AXIS_Y] = data;
      tpuv_pkg::REG_Z_LINEAR: axis_lin[tpuv_pkg::AXIS_Z] = data;
      tpuv_pkg::REG_Z_OFFSET: axis_off[tpuv_pkg::AXIS_Z] = data;
      tpuv_pkg::REG_MIRROR:   mirror_on                  = data[0];
      tpuv_pkg::REG_PROJ_OK:  projector_ready            = data[0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_axis_maps(input logic [63:0] xl, input logic [63:0] xo,
                                input logic [63:0] yl, input logic [63:0] yo,
                                input logic [63:0] zl, input logic [63:0] zo);
    write_reg(tpuv_pkg::REG_X_LINEAR, xl);
    write_reg(tpuv_pkg::REG_X_OFFSET, xo);
    write_reg(tpuv_pkg::REG_Y_LINEAR, yl);
    write_reg(tpuv_pkg::REG_Y_OFFSET, yo);
    write_reg(tpuv_pkg::REG_Z_LINEAR, zl);
    write_reg(tpuv_pkg::REG_Z_OFFSET, zo);
  endtask

  // Straight out of reset the projector is not valid, so every point reports
  // the missing projector, even when both fetches failed as well.
  task automatic test_reset_defaults();
    send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h7FFF, 16'h0, 16'h0,
                          1'b1, 1'b1), 0);
    send_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0, 16'h0,
                          16'h8000, 1'b1, 1'b1), 0);
    send_point(make_point($urandom(), $urandom(), $urandom(), 16'h1234, 16'h4000, 16'hC000,
                          1'b0, 1'b0), 0);
    settle();
  endtask

  // Missing position outranks missing normal.
  task automatic test_status_order();
    write_reg(tpuv_pkg::REG_PROJ_OK, 64'd1);
    send_point(make_point($urandom(), $urandom(), $urandom(), 16'h4000, 16'h0, 16'h0,
                          1'b0, 1'b0), 0);
    send_point(make_point($urandom(), $urandom(), $urandom(), 16'h4000, 16'h0, 16'h0,
                          1'b0, 1'b1), 0);
    send_point(make_point($urandom(), $urandom(), $urandom(), 16'h4000, 16'h0, 16'h0,
                          1'b1, 1'b0), 0);
    settle();
  endtask

  // Axis pick with identity maps: ties keep the earlier axis, and the most
  // negative component counts with its full magnitude.
  task automatic test_axis_choice();
    load_axis_maps(64'h1000_0000_0000_1000, 64'h0, 64'h1000_0000_0000_1000, 64'h0,
                   64'h1000_0000_0000_1000, 64'h0);
    write_reg(tpuv_pkg::REG_MIRROR, 64'd0);
    send_point(make_point(rand_pos(), rand_pos(), rand_pos(), 16'h0000, 16'h0000, 16'h0000,
                          1'b1, 1'b1), 0);
    send_point(make_point(rand_pos(), rand_pos(), rand_pos(), 16'h0005, 16'hFFFB, 16'h0005,
                          1'b1, 1'b1), 0);
    send_point(make_point(rand_pos(), rand_pos(), rand_pos(), 16'h0001, 16'hFFFE, 16'h0002,
                          1'b1, 1'b1), 0);
    send_point(make_point(rand_pos(), rand_pos(), rand_pos(), 16'h0000, 16'h0000, 16'h8000,
                          1'b1, 1'b1), 0);
    send_point(make_point(rand_pos(), rand_pos(), rand_pos(), 16'h8000, 16'h7FFF, 16'h7FFF,
                          1'b1, 1'b1), 0);
    send_point(make_point(rand_pos(), rand_pos(), rand_pos(), 16'h7FFF, 16'h8000, 16'h0000,
                          1'b1, 1'b1), 0);
    send_point(make_point(rand_pos(), rand_pos(), rand_pos(), 16'h0064, 16'h0064, 16'hFF9B,
                          1'b1, 1'b1), 0);
    settle();
  endtask

  // Extreme coefficients and offsets on the X and Y axes, extreme positions on
  // every axis, with the mirror on and then off.
  task automatic test_coordinate_extremes();
    tpuv_pkg::in_word_t w;
    logic [15:0] axis_norm [3][3];
    axis_norm = '{'{16'h7FFF, 16'h0, 16'h0}, '{16'h0, 16'h8000, 16'h0},
                  '{16'h0, 16'h0, 16'h7FFF}};
    load_axis_maps(64'h7FFF_8000_8000_7FFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h8000_8000_8000_8000, 64'h8000_0000_8000_0000,
                   {$urandom(), $urandom()}, 64'h0000_0000_0000_0000);
    write_reg(tpuv_pkg::REG_MIRROR, 64'd1);
    for (int a = 0; a < 3; a++) begin
      w = make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     axis_norm[a][0], axis_norm[a][1], axis_norm[a][2], 1'b1, 1'b1);
      send_point(w, 0);
      w.pos_x = 32'h8000_0000;
      w.pos_y = 32'h8000_0000;
      w.pos_z = 32'h8000_0000;
      send_point(w, 0);
    end
    settle();
    write_reg(tpuv_pkg::REG_MIRROR, 64'd0);
    for (int a = 0; a < 3; a++) begin
      send_point(make_point(32'hFFFF_8000, 32'h7FFF_FFFF, 32'h8000_0000,
                            axis_norm[a][0], axis_norm[a][1], axis_norm[a][2],
                            1'b1, 1'b1), 0);
    end
    settle();
  endtask

  // Random streams under several register settings. The second and third
  // settings pin the coefficients and offsets to their extremes.
  task automatic test_random_stream();
    int gap_pct [3];
    gap_pct = '{0, 49, 23};
    for (int s = 0; s < RANDOM_SETS; s++) begin
      case (s)
        1: load_axis_maps({4{16'h7FFF}}, {64{1'b1}}, {4{16'h7FFF}}, {64{1'b1}},
                          {4{16'h7FFF}}, {64{1'b1}});
        2: load_axis_maps({4{16'h8000}}, {2{32'h8000_0000}}, {4{16'h8000}},
                          {2{32'h8000_0000}}, {4{16'h8000}}, {2{32'h8000_0000}});
        default: load_axis_maps({$urandom(), $urandom()}, {$urandom(), $urandom()},
                                {$urandom(), $urandom()}, {$urandom(), $urandom()},
                                {$urandom(), $urandom()}, {$urandom(), $urandom()});
      endcase
      write_reg(tpuv_pkg::REG_MIRROR, {$urandom(), $urandom()});
      write_reg(tpuv_pkg::REG_PROJ_OK,
                (s == RANDOM_SETS - 1) ? 64'(($urandom_range(3) != 0)) : 64'd1);
      for (int i = 0; i < POINTS_PER_SET; i++) begin
        send_point(rand_point(), gap_pct[s % 3]);
      end
      settle();
    end
  endtask

  // Result checker: every word marked by done is compared with the oldest
  // prediction, one field at a time.
  always @(posedge clk) begin
    tpuv_pkg::result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_uv.size() == 0) begin
        $error("result word arrived with no prediction pending: %h", result);
        error_count++;
      end else begin
        want = expected_uv.pop_front();
        if (result.u_coord !== want.u_coord) begin
          $error("u_coord: expected %h, got %h", want.u_coord, result.u_coord);
          error_count++;
        end
        if (result.v_coord !== want.v_coord) begin
          $error("v_coord: expected %h, got %h", want.v_coord, result.v_coord);
          error_count++;
        end
        if (result.axis_used !== want.axis_used) begin
          $error("axis_used: expected %0d, got %0d", want.axis_used, result.axis_used);
          error_count++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles with no activity", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    in_word         = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    points_sent     = 0;
    results_seen    = 0;
    reg_writes      = 0;
    error_count     = 0;
    quiet_cycles    = 0;
    for (int a = 0; a < 3; a++) begin
      axis_lin[a] = '0;
      axis_off[a] = '0;
    end
    mirror_on       = 1'b0;
    projector_ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_status_order();
    test_axis_choice();
    test_coordinate_extremes();
    test_random_stream();

    settle();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    $display("Covered %0d shading points and %0d result words over %0d register writes,",
             points_sent, results_seen, reg_writes);
    $display("including status priority, axis ties, mirroring and extreme maps.");
    if (error_count == 0 && expected_uv.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
